@@ design/hpl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg: shared constants, arctangent table and stage types
// Holds the fixed Q30 constants, the datapath width used by the ratio divider,
// square root and vectoring pipelines, and the CORDIC angle table.
// ----------------------------------------------------------------------------
package hpl_pkg;

  localparam int COORD_BITS_DEF      = 13;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STEPS_DEF    = 16;

  localparam int QW = 34;  // signed Q30 datapath width with headroom

  localparam logic signed [QW-1:0] Q30_ONE = QW'(64'sd1073741824);
  localparam logic signed [QW-1:0] Q30_PI  = QW'(64'sd3373259426);

  function automatic logic signed [QW-1:0] atan_q30(input int i);
    logic signed [QW-1:0] v;
    begin
      unique case (i)
        0:  v = QW'(64'sd843314857);
        1:  v = QW'(64'sd497837829);
        2:  v = QW'(64'sd263043837);
        3:  v = QW'(64'sd133525159);
        4:  v = QW'(64'sd67021687);
        5:  v = QW'(64'sd33543516);
        6:  v = QW'(64'sd16775851);
        7:  v = QW'(64'sd8388437);
        8:  v = QW'(64'sd4194283);
        9:  v = QW'(64'sd2097149);
        10: v = QW'(64'sd1048576);
        11: v = QW'(64'sd524288);
        12: v = QW'(64'sd262144);
        13: v = QW'(64'sd131072);
        14: v = QW'(64'sd65536);
        15: v = QW'(64'sd32768);
        16: v = QW'(64'sd16384);
        17: v = QW'(64'sd8192);
        18: v = QW'(64'sd4096);
        19: v = QW'(64'sd2048);
        20: v = QW'(64'sd1024);
        21: v = QW'(64'sd512);
        22: v = QW'(64'sd256);
        23: v = QW'(64'sd128);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // One vectoring problem: atan2(y, x) with x >= 0, plus an offset held in z.
  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } cordic_t;

endpackage
`default_nettype wire

@@ design/head_pose_from_landmarks.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// head_pose_from_landmarks: yaw, pitch and roll from facial landmarks
// Streams one landmark set per word in, one pose word out.
// ----------------------------------------------------------------------------
// Input channel s_axis: one landmark set per word, nine signed coordinates.
// Output channel m_axis: one pose word per input word, in order.
// Throughput is one word per cycle while the output is not stalled. The
// pipeline is one prepare stage, 32 divider stages and 32 square root
// stages for the asin ratios, then CORDIC_STEPS vectoring stages and one
// output stage. The roll path is delayed to line up with yaw and pitch.
// The whole pipeline advances only while the output register is empty or
// being taken, so when the receiver holds m_axis_tready low the pipeline
// freezes and nothing is lost or repeated; s_axis_tready follows the same
// condition. Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module head_pose_from_landmarks
  import hpl_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // nose_x, nose_y, chin_y, bridge_upper_y, bridge_lower_y, left_eye_x,
  // left_eye_y, right_eye_x, right_eye_y, each COORD_BITS, zero fill
  input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // yaw_angle 15, pitch_angle 15, roll_angle 16, yaw_valid, pitch_valid,
  // roll_valid, zero fill
  output logic [55:0] m_axis_tdata
);

  localparam int CB = COORD_BITS;
  localparam int NW = CB + 3;
  localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam int LAT = 64;  // ratio unit depth incl. its input stages

  logic en;
  logic ov;
  assign en = !ov || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [CB-1:0] f [9];
  for (genvar k = 0; k < 9; k++) begin : g_f
    assign f[k] = s_axis_tdata[k*CB +: CB];
  end

  logic signed [NW-1:0] nx, ny, cy, bu, bl, lx, ly, rx, ry;
  assign nx = NW'(f[0]);
  assign ny = NW'(f[1]);
  assign cy = NW'(f[2]);
  assign bu = NW'(f[3]);
  assign bl = NW'(f[4]);
  assign lx = NW'(f[5]);
  assign ly = NW'(f[6]);
  assign rx = NW'(f[7]);
  assign ry = NW'(f[8]);

  // Prepare stage.
  logic                 p_v;
  logic signed [NW-1:0] p_yn, p_pn, p_h, p_dx, p_dy;
  logic [NW-1:0]        p_w;
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_yn <= lx + rx - (nx <<< 1);
      p_pn <= (cy - ny) <<< 1;
      p_h  <= (cy <<< 1) - bu - bl;
      p_dx <= rx - lx;
      p_dy <= ry - ly;
      p_w  <= (rx - lx) < 0 ? NW'((lx - rx) <<< 1) : NW'((rx - lx) <<< 1);
    end
  end

  logic yv_p, pv_p;
  assign yv_p = (p_dx != '0);
  assign pv_p = !p_h[NW-1] && (p_h != '0);

  // Yaw and pitch ratio units; each uses den 1 when invalid, result discarded.
  logic                 ry_v, rp_v;
  logic signed [QW-1:0] ys, yc, ps, pc;
  logic [0:0]           ry_side, rp_side;

  hpl_ratio #(.NW(NW), .SW(1)) u_yaw_ratio (
    .clk, .rst, .en, .in_v(p_v), .num(p_yn),
    .den(yv_p ? p_w : NW'(1)), .side_in(yv_p),
    .out_v(ry_v), .sin_q(ys), .cos_q(yc), .side_out(ry_side)
  );

  hpl_ratio #(.NW(NW), .SW(1)) u_pitch_ratio (
    .clk, .rst, .en, .in_v(p_v), .num(p_pn),
    .den(pv_p ? NW'(p_h) : NW'(1)), .side_in(pv_p),
    .out_v(rp_v), .sin_q(ps), .cos_q(pc), .side_out(rp_side)
  );

  // Roll delay line to match ratio latency.
  logic signed [NW-1:0] dl_dx [LAT];
  logic signed [NW-1:0] dl_dy [LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_dx[0] <= p_dx;
      dl_dy[0] <= p_dy;
      for (int i = 1; i < LAT; i++) begin
        dl_dx[i] <= dl_dx[i-1];
        dl_dy[i] <= dl_dy[i-1];
      end
    end
  end

  logic signed [NW-1:0] rdx, rdy;
  assign rdx = dl_dx[LAT-1];
  assign rdy = dl_dy[LAT-1];

  logic signed [QW-1:0] rxs, rys;
  assign rxs = QW'(rdx) <<< (30 - CB);
  assign rys = QW'(rdy) <<< (30 - CB);

  // Build vectoring inputs; a negative x is folded with a +-pi offset.
  cordic_t cy_in, cp_in, cr_in;
  logic signed [QW-1:0] roff;
  always_comb begin
    cy_in = '{x: yc, y: ys, z: '0};
    cp_in = '{x: pc, y: ps, z: '0};
    if (rxs[QW-1]) begin
      roff  = rys[QW-1] ? -Q30_PI : Q30_PI;
      cr_in = '{x: -rxs, y: -rys, z: roff};
    end else begin
      roff  = '0;
      cr_in = '{x: rxs, y: rys, z: '0};
    end
  end

  logic                 cy_v, cp_v, cr_v;
  logic signed [QW-1:0] ya, pa, ra;
  logic [0:0]           cy_s, cp_s, cr_s;

  hpl_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_yaw_cordic (
    .clk, .rst, .en, .in_v(ry_v), .in_d(cy_in), .side_in(ry_side),
    .out_v(cy_v), .angle(ya), .side_out(cy_s)
  );
  hpl_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_pitch_cordic (
    .clk, .rst, .en, .in_v(rp_v), .in_d(cp_in), .side_in(rp_side),
    .out_v(cp_v), .angle(pa), .side_out(cp_s)
  );
  hpl_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_roll_cordic (
    .clk, .rst, .en, .in_v(ry_v), .in_d(cr_in), .side_in(ry_side),
    .out_v(cr_v), .angle(ra), .side_out(cr_s)
  );

  function automatic logic [15:0] to_field(input logic signed [QW-1:0] z, input int w);
    logic signed [QW:0] t;
    logic signed [QW:0] lim;
    begin
      t   = ((QW+1)'(z) + ((QW+1)'(1) <<< (SHIFT - 1))) >>> SHIFT;
      lim = ((QW+1)'(1) <<< (w - 1)) - 1;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return 16'(t);
    end
  endfunction

  logic [14:0] o_yaw, o_pitch;
  logic [15:0] o_roll;
  logic        o_yv, o_pv, o_rv;
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= cy_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_yv    <= cy_s[0];
      o_pv    <= cp_s[0];
      o_rv    <= cr_s[0];
      o_yaw   <= cy_s[0] ? 15'(to_field(ya, 15)) : 15'(0);
      o_pitch <= cp_s[0] ? 15'(to_field(pa, 15)) : 15'(0);
      o_roll  <= cr_s[0] ? to_field(ra, 16) : 16'(0);
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {5'b0, o_rv, o_pv, o_yv, o_roll, o_pitch, o_yaw};

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (cy_v == cp_v) && (cy_v == cr_v))
    else $error("pose lanes out of step");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ov && !m_axis_tready |=> ov && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    ov && !o_yv |-> o_yaw == '0 && o_roll == '0)
    else $error("invalid angle not zero");
  a_roll_yaw_flag: assert property (@(posedge clk) disable iff (rst)
    ov |-> o_yv == o_rv)
    else $error("yaw and roll flags disagree");
`endif

endmodule
`default_nettype wire

@@ design/hpl_ratio.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ratio: pipelined Q30 ratio and asin cosine leg
// Forms r = min(|n|/d, 1) in Q30 one quotient bit a stage, then the cosine
// leg floor(sqrt(2^60 - r^2)) one result bit a stage. Carries a side
// payload along so the caller keeps alignment.
// ----------------------------------------------------------------------------
module hpl_ratio
  import hpl_pkg::*;
#(
  parameter int NW = 16,  // width of the signed numerator
  parameter int SW = 8    // side payload width
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_v,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [NW-1:0]        den,
  input  wire logic [SW-1:0]        side_in,
  output logic                      out_v,
  output logic signed [QW-1:0]      sin_q,
  output logic signed [QW-1:0]      cos_q,
  output logic [SW-1:0]             side_out
);

  localparam int DS = 31;  // quotient bits 30..0
  localparam int SS = 31;  // root bits 30..0
  localparam int RW = NW + 1;

  // Divider stages.
  logic [DS:0]       dv;
  logic [RW-1:0]     drem [DS+1];
  logic [NW-1:0]     dden [DS+1];
  logic [30:0]       dq   [DS+1];
  logic              dneg [DS+1];
  logic              dsat [DS+1];
  logic [SW-1:0]     dside[DS+1];

  logic [NW-1:0] an;
  assign an = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[DS-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]  <= RW'(an);
      dden[0]  <= den;
      dq[0]    <= '0;
      dneg[0]  <= num[NW-1];
      dsat[0]  <= (an >= den);
      dside[0] <= side_in;
    end
  end

  // Restoring division: each stage doubles the remainder (the first stage
  // takes it as is) and subtracts den where it fits, giving quotient bit k.
  for (genvar s = 0; s < DS; s++) begin : g_div
    localparam int K = 30 - s;
    logic [RW:0] wv;
    logic        take;
    assign wv   = (s == 0) ? (RW+1)'(drem[s]) : ((RW+1)'(drem[s]) << 1);
    assign take = wv >= (RW+1)'(dden[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        drem[s+1]  <= take ? RW'(wv - (RW+1)'(dden[s])) : RW'(wv);
        dq[s+1]    <= dq[s] | (take ? (31'(1) << K) : 31'(0));
        dden[s+1]  <= dden[s];
        dneg[s+1]  <= dneg[s];
        dsat[s+1]  <= dsat[s];
        dside[s+1] <= dside[s];
      end
    end
  end

  logic [30:0] r;
  assign r = dsat[DS] ? 31'h40000000 : dq[DS];

  // Square root of v = 2^60 - r^2 by the bit-pair method; r^2 is one multiply.
  logic [SS:0]   sv;
  logic [61:0]   sval [SS+1];
  logic [31:0]   sres [SS+1];
  logic [30:0]   sr   [SS+1];
  logic          sneg [SS+1];
  logic [SW-1:0] sside[SS+1];
  logic [61:0]   rsq;
  assign rsq = 62'(r) * 62'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[SS-1:0], dv[DS]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sval[0]  <= (62'(1) << 60) - rsq;
      sres[0]  <= '0;
      sr[0]    <= r;
      sneg[0]  <= dneg[DS];
      sside[0] <= dside[DS];
    end
  end

  for (genvar s = 0; s < SS; s++) begin : g_sqrt
    localparam int B = 2 * (30 - s);
    logic [62:0] trial;
    logic [62:0] resw;
    assign resw  = 63'(sres[s]) << (30 - s + 1);
    assign trial = resw + (63'(1) << B);
    always_ff @(posedge clk) begin
      if (en) begin
        if (63'(sval[s]) >= trial) begin
          sval[s+1] <= 62'(63'(sval[s]) - trial);
          sres[s+1] <= sres[s] | (32'(1) << (30 - s));
        end else begin
          sval[s+1] <= sval[s];
          sres[s+1] <= sres[s];
        end
        sr[s+1]    <= sr[s];
        sneg[s+1]  <= sneg[s];
        sside[s+1] <= sside[s];
      end
    end
  end

  assign out_v    = sv[SS];
  assign sin_q    = sneg[SS] ? -QW'(sr[SS]) : QW'(sr[SS]);
  assign cos_q    = QW'(sres[SS]);
  assign side_out = sside[SS];

endmodule
`default_nettype wire

@@ design/hpl_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_cordic: pipelined CORDIC vectoring unit
// One micro-rotation per register stage, accumulating angle in Q30.
// ----------------------------------------------------------------------------
module hpl_cordic
  import hpl_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int SW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire cordic_t       in_d,
  input  wire logic [SW-1:0] side_in,
  output logic               out_v,
  output logic signed [QW-1:0] angle,
  output logic [SW-1:0]      side_out
);

  logic [STEPS:0]  v;
  cordic_t         st   [STEPS+1];
  logic [SW-1:0]   side [STEPS+1];

  assign v[0]    = in_v;
  assign st[0]   = in_d;
  assign side[0] = side_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [QW-1:0] xs;
    logic signed [QW-1:0] ys;
    assign xs = st[i].x >>> i;
    assign ys = st[i].y >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!st[i].y[QW-1]) begin
          st[i+1].x <= st[i].x + ys;
          st[i+1].y <= st[i].y - xs;
          st[i+1].z <= st[i].z + atan_q30(i);
        end else begin
          st[i+1].x <= st[i].x - ys;
          st[i+1].y <= st[i].y + xs;
          st[i+1].z <= st[i].z - atan_q30(i);
        end
        side[i+1] <= side[i];
      end
    end
  end

  assign out_v    = v[STEPS];
  assign angle    = st[STEPS].z;
  assign side_out = side[STEPS];

endmodule
`default_nettype wire

@@ tb/sv/tb_head_pose_from_landmarks.sv @@
// ----------------------------------------------------------------------------
// tb_head_pose_from_landmarks: stream test of the head pose estimator
// Drives landmark words with random gaps, stalls the pose output at random,
// and checks every pose word against a fixed-point model of the angle math.
// ----------------------------------------------------------------------------
typedef struct {
  logic signed [14:0] yaw;
  logic signed [14:0] pitch;
  logic signed [15:0] roll;
  logic yaw_ok;
  logic pitch_ok;
  logic roll_ok;
} pose_t;

class pose_scoreboard;
  pose_t pending[$];
  int errors;

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint cordic(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < hpl_pkg::CORDIC_STEPS_DEF; i++) begin
      if (y >= 0) begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += longint'(hpl_pkg::atan_q30(i));
      end else begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= longint'(hpl_pkg::atan_q30(i));
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  static function longint atan2_q30(longint y, longint x);
    if (x < 0) return ((y >= 0) ? 64'sd3373259426 : -64'sd3373259426) + cordic(-x, -y);
    return cordic(x, y);
  endfunction

  static function longint isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  static function longint asin_q30(longint n, longint d);
    longint an, r, c;
    an = (n < 0) ? -n : n;
    if (an >= d) r = 64'sd1 << 30;
    else r = (an << 30) / d;
    c = isqrt((64'd1 << 60) - longint'(r * r));
    return atan2_q30((n < 0) ? -r : r, c);
  endfunction

  // Round to 13 fraction bits, ties upward, and saturate symmetrically.
  static function longint quantize(longint z, int width);
    longint v, lim, bias;
    bias = 64'sd8 << 30;
    lim = (64'sd1 << (width - 1)) - 1;
    v = ((z + bias + (64'sd1 << 16)) >>> 17) - (bias >>> 17);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function void note_landmarks(logic [119:0] w);
    longint c[9];
    longint h, dx, dy;
    pose_t p;
    for (int k = 0; k < 9; k++) c[k] = longint'($signed(w[k*13 +: 13]));
    h = 2 * c[2] - c[3] - c[4];
    dx = c[7] - c[5];
    dy = c[8] - c[6];
    p = '{default: 0};
    if (dx != 0) begin
      p.yaw = 15'(quantize(asin_q30(c[5] + c[7] - 2 * c[0], 2 * ((dx < 0) ? -dx : dx)), 15));
      p.yaw_ok = 1;
      p.roll = 16'(quantize(atan2_q30(dy << 17, dx << 17), 16));
      p.roll_ok = 1;
    end
    if (h > 0) begin
      p.pitch = 15'(quantize(asin_q30(2 * (c[2] - c[1]), h), 15));
      p.pitch_ok = 1;
    end
    pending.push_back(p);
  endfunction

  function void check_pose(logic [55:0] w);
    pose_t e;
    if (pending.size() == 0) begin
      $error("pose word with nothing expected: %h", w);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (w[14:0] !== e.yaw) begin
      $error("yaw_angle expected %0d actual %0d", e.yaw, $signed(w[14:0])); errors++;
    end
    if (w[29:15] !== e.pitch) begin
      $error("pitch_angle expected %0d actual %0d", e.pitch, $signed(w[29:15])); errors++;
    end
    if (w[45:30] !== e.roll) begin
      $error("roll_angle expected %0d actual %0d", e.roll, $signed(w[45:30])); errors++;
    end
    if (w[46] !== e.yaw_ok) begin
      $error("yaw_valid expected %0d actual %0d", e.yaw_ok, w[46]); errors++;
    end
    if (w[47] !== e.pitch_ok) begin
      $error("pitch_valid expected %0d actual %0d", e.pitch_ok, w[47]); errors++;
    end
    if (w[48] !== e.roll_ok) begin
      $error("roll_valid expected %0d actual %0d", e.roll_ok, w[48]); errors++;
    end
  endfunction
endclass

module tb_head_pose_from_landmarks;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  longint cycles = 0;
  pose_scoreboard board = new();

  head_pose_from_landmarks dut (.*);

  always #6 clk = ~clk;

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [12:0] coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 13'h0fff;
    if (r == 1) return 13'h1000;
    if (r < 5) return 13'($signed($urandom_range(0, 200)) - 100);
    return 13'($urandom);
  endfunction

  // Plausible face: eyes apart, chin below the bridge, small offsets.
  function automatic logic [119:0] face_word();
    int cx, cy;
    int c[9];
    logic [119:0] w;
    cx = $urandom_range(0, 2000) - 1000;
    cy = $urandom_range(0, 2000) - 1000;
    c[0] = cx + $urandom_range(0, 80) - 40;
    c[1] = cy + $urandom_range(0, 80) - 40;
    c[2] = cy + $urandom_range(0, 200);
    c[3] = cy - $urandom_range(0, 200);
    c[4] = cy - $urandom_range(0, 100);
    c[5] = cx - $urandom_range(0, 300);
    c[6] = cy - 60 + $urandom_range(0, 60) - 30;
    c[7] = cx + $urandom_range(0, 300);
    c[8] = cy - 60 + $urandom_range(0, 60) - 30;
    w = '0;
    for (int k = 0; k < 9; k++) w[k*13 +: 13] = 13'(c[k]);
    return w;
  endfunction

  task automatic send_landmarks(logic [119:0] w);
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_landmarks(w);
  endtask

  task automatic send_with_gap(logic [119:0] w);
    int g;
    g = gap_length();
    if (g > 0 && $urandom_range(0, 3) != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    send_landmarks(w);
  endtask

  function automatic logic [119:0] nine(int a0, int a1, int a2, int a3, int a4,
                                        int a5, int a6, int a7, int a8);
    int c[9];
    logic [119:0] w;
    c = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    w = '0;
    for (int k = 0; k < 9; k++) w[k*13 +: 13] = 13'(c[k]);
    return w;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, with calm stretches.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_pose(m_axis_tdata);
    if (rst) m_axis_tready <= 0;
    else if ((cycles / 500) % 3 == 0) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 9) < 7) ||
                          ($urandom_range(0, 30) == 0 ? 0 : $urandom_range(0, 1));
  end

  initial begin
    int wait_cnt;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, invalid cases, clamped ratios, negative dx.
    send_landmarks('0);
    send_landmarks({120{1'b1}});
    send_landmarks(nine(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    send_landmarks(nine(-4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096));
    send_landmarks(nine(0, 0, 4095, -4096, -4096, -4096, 0, 4095, 0));
    send_landmarks(nine(4095, -4096, 4095, -4096, -4096, 4095, 4095, -4096, -4096));
    send_landmarks(nine(-4096, 4095, -4096, 4095, 4095, -4096, -4096, 4095, 4095));
    send_landmarks(nine(0, 10, 20, 0, 0, 10, 0, -10, 0));
    send_landmarks(nine(0, 0, 10, 0, 0, 5, 3, -5, 3));
    send_landmarks(nine(0, 0, 10, 0, 0, 5, 3, -5, 7));
    send_landmarks(nine(0, 0, 10, 0, 0, 5, 3, -5, -7));
    send_landmarks(nine(100, 0, 10, 0, 0, -5, 0, 5, 0));
    send_landmarks(nine(-100, 50, 10, 0, 0, -5, 0, 5, 4));
    send_landmarks(nine(0, 5, 10, 0, 0, -5, 0, 5, 0));
    send_landmarks(nine(0, 5, 5, 5, 5, 3, 0, 3, 9));
    send_landmarks(nine(0, 3, 1, 0, 1, 0, 0, 1, 4095));
    send_landmarks(nine(1, 0, 1, 0, 1, -1, -4096, 1, 4095));
    send_landmarks(nine(0, 7, 10, 0, 0, -8, 0, 8, 0));
    // Hold off until everything is drained.
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    for (int n = 0; n < 1200; n++) begin
      if ($urandom_range(0, 3) != 0) send_with_gap(face_word());
      else send_with_gap({$urandom_range(0, 1) ? 3'b111 : 3'b000,
                          coord(), coord(), coord(), coord(), coord(),
                          coord(), coord(), coord(), coord()});
    end
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 200) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
